[rtl/cfbf_pkg.sv]
// shared types and constants of the can frame byte fifo
`default_nettype none

package cfbf_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 80;
  localparam int unsigned MAX_PAYLOAD     = 8;
  localparam int unsigned ID_W            = 11;
  localparam int unsigned LEN_W           = 4;
  localparam int unsigned FILL_W          = 7;
  localparam int unsigned DROP_W          = 4;
  localparam logic [ID_W-1:0] ACCEPTED_ID_RST = 11'd2;

  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic              extended_frame;
    logic [ID_W-1:0]   frame_id;
    logic [LEN_W-1:0]  frame_length;
    logic [7:0]        data_byte_0;
    logic [7:0]        data_byte_1;
    logic [7:0]        data_byte_2;
    logic [7:0]        data_byte_3;
    logic [7:0]        data_byte_4;
    logic [7:0]        data_byte_5;
    logic [7:0]        data_byte_6;
    logic [7:0]        data_byte_7;
  } req_t;

  typedef struct packed {
    logic [7:0]        read_byte;
    logic              read_valid;
    logic [FILL_W-1:0] fill_level;
    logic [DROP_W-1:0] bytes_dropped;
  } rsp_t;

endpackage

`default_nettype wire

[rtl/cfbf_store.sv]
// byte store: one write port, one read port with registered read data
`default_nettype none

module cfbf_store #(
  parameter int unsigned DEPTH = 80,
  parameter int unsigned AW    = 7
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic [7:0]         rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[rtl/can_frame_byte_fifo_top.sv]
// top level of the can frame byte fifo: frame filter, byte ring and read path
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  cfbf_pkg::req_t (frame or read)
//   rsp      out        rsp_valid / rsp_ready  cfbf_pkg::rsp_t (one per item)
//   cfg      in         cfg_valid / cfg_ready  accepted_id, 11 bits
//
// one item at a time; a frame passes through S_WRITE and then S_RESULT, a read through
// S_READ and then S_RESULT, ignored frames and empty reads go straight to S_RESULT
// frames are written through the single write port of the byte store, one byte a cycle
// rsp sits in an output register, so the next item is taken while it waits
// a stalled rsp only holds the result step; the store is untouched meanwhile
// synchronous reset empties the ring (indices zero, count zero), no clearing pass
`default_nettype none

module can_frame_byte_fifo_top #(
  parameter int unsigned QUEUE_DEPTH = cfbf_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    req_valid,
  output logic                         req_ready,
  input  wire cfbf_pkg::req_t          req,
  output logic                         rsp_valid,
  input  wire logic                    rsp_ready,
  output cfbf_pkg::rsp_t               rsp,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [cfbf_pkg::ID_W-1:0] cfg_data
);
  import cfbf_pkg::*;

  // index and count widths follow the ring depth
  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_WRITE, S_READ, S_RESULT} state_t;

  state_t              state;
  req_t                req_q;        // captured item, walked byte by byte
  logic [LEN_W-1:0]    remain;       // bytes of the frame still to place
  logic [2:0]          slot;         // payload byte being placed
  logic [AW-1:0]       wr_idx;
  logic [AW-1:0]       rd_idx;
  logic [CW-1:0]       count;        // bytes held in the ring
  logic [DROP_W-1:0]   dropped;
  logic [7:0]          res_byte;
  logic                res_valid;
  logic [ID_W-1:0]     accepted_id;

  logic                id_match;
  logic [LEN_W-1:0]    len_sat;
  logic                full;
  logic                store_wr;
  logic [7:0]          cur_byte;
  logic [7:0]          store_rd_data;
  logic [AW-1:0]       wr_idx_next;
  logic [AW-1:0]       rd_idx_next;

  assign req_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // frame filter: standard format and identifier equal to the register
  assign id_match = !req.extended_frame && (req.frame_id == accepted_id);
  // data length codes above eight mean eight bytes
  assign len_sat  = (req.frame_length > LEN_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD)
                                                              : req.frame_length;

  assign full     = (count == FULL_CNT);
  assign store_wr = (state == S_WRITE) && !full;

  // wrapping ring indices
  assign wr_idx_next = (wr_idx == LAST_IDX) ? '0 : wr_idx + AW'(1);
  assign rd_idx_next = (rd_idx == LAST_IDX) ? '0 : rd_idx + AW'(1);

  always_comb begin
    unique case (slot)
      3'd0:    cur_byte = req_q.data_byte_0;
      3'd1:    cur_byte = req_q.data_byte_1;
      3'd2:    cur_byte = req_q.data_byte_2;
      3'd3:    cur_byte = req_q.data_byte_3;
      3'd4:    cur_byte = req_q.data_byte_4;
      3'd5:    cur_byte = req_q.data_byte_5;
      3'd6:    cur_byte = req_q.data_byte_6;
      default: cur_byte = req_q.data_byte_7;
    endcase
  end

  // the read port looks at rd_idx every cycle; the last write of a frame lands
  // before a read item can be accepted, with S_RESULT lying between them, so the data that
  // arrives in S_READ is never stale
  cfbf_store #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (store_wr),
    .wr_addr (wr_idx),
    .wr_data (cur_byte),
    .rd_addr (rd_idx),
    .rd_data (store_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rsp_valid   <= 1'b0;
      wr_idx      <= '0;
      rd_idx      <= '0;
      count       <= '0;
      accepted_id <= ACCEPTED_ID_RST;
    end else begin
      if (cfg_valid) begin
        accepted_id <= cfg_data;
      end
      // the result step refills the output register itself when it drains
      if (rsp_valid && rsp_ready && (state != S_RESULT)) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            req_q     <= req;
            dropped   <= '0;
            res_byte  <= '0;
            res_valid <= 1'b0;
            slot      <= '0;
            remain    <= len_sat;
            if (req.opcode == OP_READ) begin
              // empty ring answers at once with read_valid low
              state <= (count != '0) ? S_READ : S_RESULT;
            end else begin
              state <= (id_match && (len_sat != '0)) ? S_WRITE : S_RESULT;
            end
          end
        end
        S_WRITE: begin
          // one payload byte per cycle, a byte that meets a full ring is counted
          if (full) begin
            dropped <= dropped + DROP_W'(1);
          end else begin
            wr_idx <= wr_idx_next;
            count  <= count + CW'(1);
          end
          slot   <= slot + 3'd1;
          remain <= remain - LEN_W'(1);
          if (remain == LEN_W'(1)) begin
            state <= S_RESULT;
          end
        end
        S_READ: begin
          res_byte  <= store_rd_data;
          res_valid <= 1'b1;
          rd_idx    <= rd_idx_next;
          count     <= count - CW'(1);
          state     <= S_RESULT;
        end
        S_RESULT: begin
          // wait only for the output register to free up
          if (!rsp_valid || rsp_ready) begin
            rsp_valid         <= 1'b1;
            rsp.read_byte     <= res_byte;
            rsp.read_valid    <= res_valid;
            rsp.fill_level    <= FILL_W'(count);
            rsp.bytes_dropped <= dropped;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/cfbf_checker.sv]
// port-level checker of the can frame byte fifo and its bind
`default_nettype none

module cfbf_checker #(
  parameter int unsigned QUEUE_DEPTH = cfbf_pkg::QUEUE_DEPTH_DEF
) (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      req_valid,
  input wire logic                      req_ready,
  input wire cfbf_pkg::req_t            req,
  input wire logic                      rsp_valid,
  input wire logic                      rsp_ready,
  input wire cfbf_pkg::rsp_t            rsp,
  input wire logic                      cfg_valid,
  input wire logic                      cfg_ready,
  input wire logic [cfbf_pkg::ID_W-1:0] cfg_data
);
  import cfbf_pkg::*;

  localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(QUEUE_DEPTH);

  // a result waiting on a stall holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("rsp changed while stalled");

  // nothing comes out right after reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("rsp valid after reset");

  // a delivered byte never comes with drops, a missing byte reads as zero
  a_read_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.read_valid |-> rsp.bytes_dropped == '0)
    else $error("read result carries drops");

  a_no_byte_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.read_valid |-> rsp.read_byte == '0)
    else $error("nonzero byte without read_valid");

  // drops only happen when the ring ends up full
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.bytes_dropped != '0) |-> rsp.fill_level == FULL_FILL)
    else $error("drops reported with ring not full");

endmodule

bind can_frame_byte_fifo_top cfbf_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_cfbf_checker (.*);

`default_nettype wire
